@@ hdl/pno_pkg.sv @@
// Shared constants for the fractal gradient noise block.
// No dependencies; imported by the channel interfaces, the top level and the checker.
package pno_pkg;

    // Gradient table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;

    // Default build choices
    localparam int DEF_MAX_OCTAVES = 16;
    localparam int DEF_FRAC_BITS   = 16;

    // Shared multiplier geometry
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int EXT_W  = 72;
    localparam int SCALE_SHIFT_BASE = 40;

    // Corner hash constants
    localparam logic [31:0] HASH_MUL_X = 32'd1836311903;
    localparam logic [31:0] HASH_MUL_Y = 32'd2971215073;
    localparam logic [31:0] HASH_ADD   = 32'd512559680;

    // Amplitude one in Q1.15
    localparam logic [15:0] AMP_ONE = 16'd32768;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Gradient codes
    localparam logic [1:0] GRAD_POS_X = 2'd0;
    localparam logic [1:0] GRAD_NEG_X = 2'd1;
    localparam logic [1:0] GRAD_POS_Y = 2'd2;
    localparam logic [1:0] GRAD_NEG_Y = 2'd3;

    // Register map
    localparam int          ADDR_W      = 4;
    localparam logic [1:0]  REG_SCALE   = 2'd0;
    localparam logic [1:0]  REG_OCTAVES = 2'd1;
    localparam logic [1:0]  REG_PERSIST = 2'd2;
    localparam logic [31:0] SCALE_RST   = 32'd16777216;
    localparam logic [4:0]  OCTAVES_RST = 5'd1;
    localparam logic [15:0] PERSIST_RST = 16'd16384;

endpackage

@@ hdl/pno_in_if.sv @@
// Input channel: valid/ready handshake carrying one command item.
// Depends on pno_pkg for the table index width.
interface pno_in_if
    import pno_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [IDX_W-1:0]  table_index;
    logic signed [7:0] table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;

    modport source (output valid, opcode, table_index, table_value, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, opcode, table_index, table_value, coord_x, coord_y,
                    output ready);
endinterface

@@ hdl/pno_out_if.sv @@
// Output channel: valid/ready handshake carrying one noise result item.
// Depends on pno_pkg only by convention of the project.
interface pno_out_if
    import pno_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

@@ hdl/perlin_noise_2d_octaves_top.sv @@
// Fractal 2D gradient noise engine with a writable 1024 x 2 gradient table.
// Depends on pno_pkg, pno_in_if and pno_out_if.
//
//  channel   | direction | carries
//  ----------+-----------+------------------------------------------------
//  in_ch     | in        | opcode, table_index, table_value, coord_x/y
//  out_ch    | out       | noise_value (Q1.15)
//  APB       | in/out    | scale, octave_count, persistence registers
//
// A table write is taken without dropping ready.
// An evaluation holds ready low until its result is loaded into the output
// register, so the next item is taken only after that. Each octave runs
// on the single shared 33x33 multiplier that carries every product in turn,
// and a 16-step restoring divider follows the last octave.
// Reset clears control state; the table is undefined until written.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a further result stalls until that register is free.
module perlin_noise_2d_octaves_top
    import pno_pkg::*;
#(
    parameter int MAX_OCTAVES = DEF_MAX_OCTAVES,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    pno_in_if.sink            in_ch,
    pno_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int PX_W  = FRAC_BITS + 32;
    localparam int FW    = FRAC_BITS + 5;
    localparam int DW    = FRAC_BITS + 3;
    localparam int TOT_W = 16 + OCT_W;
    localparam int SUM_W = FRAC_BITS + 16 + OCT_W;
    localparam int REM_W = SUM_W + 15;

    localparam logic [FW-1:0] ONE_FW     = FW'(1 << FRAC_BITS);
    localparam logic [FW-1:0] TEN_FW     = FW'(10 << FRAC_BITS);
    localparam logic [FW-1:0] FIFTEEN_FW = FW'(15 << FRAC_BITS);
    localparam logic [DW-1:0] ONE_DW     = DW'(1 << FRAC_BITS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SCX  = 5'd1;
    localparam logic [4:0] S_SCY  = 5'd2;
    localparam logic [4:0] S_PY   = 5'd3;
    localparam logic [4:0] S_HX   = 5'd4;
    localparam logic [4:0] S_HY   = 5'd5;
    localparam logic [4:0] S_R00  = 5'd6;
    localparam logic [4:0] S_R10  = 5'd7;
    localparam logic [4:0] S_R01  = 5'd8;
    localparam logic [4:0] S_R11  = 5'd9;
    localparam logic [4:0] S_G11  = 5'd10;
    localparam logic [4:0] S_FA   = 5'd11;
    localparam logic [4:0] S_FB   = 5'd12;
    localparam logic [4:0] S_FC   = 5'd13;
    localparam logic [4:0] S_FD   = 5'd14;
    localparam logic [4:0] S_FE   = 5'd15;
    localparam logic [4:0] S_L1   = 5'd16;
    localparam logic [4:0] S_L2   = 5'd17;
    localparam logic [4:0] S_L3   = 5'd18;
    localparam logic [4:0] S_L4   = 5'd19;
    localparam logic [4:0] S_L5   = 5'd20;
    localparam logic [4:0] S_L6   = 5'd21;
    localparam logic [4:0] S_L7   = 5'd22;
    localparam logic [4:0] S_L8   = 5'd23;
    localparam logic [4:0] S_DV0  = 5'd24;
    localparam logic [4:0] S_DIV  = 5'd25;
    localparam logic [4:0] S_DONE = 5'd26;

    // Configuration registers
    logic [31:0] scale_reg;
    logic [4:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic        cfg_wr;
    logic [1:0]  reg_sel;

    // Sequencer and per-item state
    logic [4:0]             state_reg, state_next;
    logic signed [31:0]     coord_x_reg, coord_y_reg;
    logic [OCT_W-1:0]       n_reg, oct_reg;
    logic [15:0]            pers_reg, amp_reg;
    logic [PX_W-1:0]        px_reg, py_reg;
    logic [31:0]            hx_reg, hy_reg;
    logic [1:0]             g00_reg, g10_reg, g01_reg, g11_reg;
    logic                   fade_y_reg;
    logic signed [FW-1:0]   b_reg;
    logic [FRAC_BITS:0]     wx_reg, wy_reg, absv_reg;
    logic signed [DW-1:0]   top_reg, bot_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [REM_W-1:0]       rem_reg, dsh_reg;
    logic [15:0]            q_reg;
    logic [3:0]             bit_cnt_reg;
    logic                   out_valid_reg;
    logic [15:0]            noise_reg;

    // Shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [EXT_W-1:0]  prod_ext;

    // Gradient memory
    logic [1:0]       gmem [TABLE_DEPTH];
    logic [1:0]       rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      hash_w, hx1, hy0, hy1;

    // Datapath helpers
    logic                   in_fire;
    logic [OCT_W-1:0]       n_clamp;
    logic [15:0]            pers_clamp;
    logic [FRAC_BITS-1:0]   fx, fy, t_sel;
    logic [31:0]            cx, cy;
    logic [FW-1:0]          t_ext;
    logic signed [FW-1:0]   fade_a, f_raw;
    logic [FRAC_BITS:0]     f_clamp;
    logic signed [DW-1:0]   dxp, dxn, dyp, dyn, d00, d10, d01, d11;
    logic signed [DW-1:0]   diff_x0, diff_x1, diff_y, prod_shr, v_w, absv_w;
    logic [OCT_W-1:0]       oct_inc;
    logic                   rem_ge;

    function automatic logic signed [DW-1:0] dot_sel(input logic [1:0] g,
                                                     input logic signed [DW-1:0] dx,
                                                     input logic signed [DW-1:0] dy);
        logic signed [DW-1:0] r;
        unique case (g)
            GRAD_POS_X: r = dx;
            GRAD_NEG_X: r = -dx;
            GRAD_POS_Y: r = dy;
            GRAD_NEG_Y: r = -dy;
        endcase
        return r;
    endfunction

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_comb
    begin
        unique case (reg_sel)
            REG_SCALE:   prdata = scale_reg;
            REG_OCTAVES: prdata = {27'd0, octave_count_reg};
            REG_PERSIST: prdata = {16'd0, persistence_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg        <= SCALE_RST;
            octave_count_reg <= OCTAVES_RST;
            persistence_reg  <= PERSIST_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == REG_SCALE)   scale_reg        <= pwdata;
            if (reg_sel == REG_OCTAVES) octave_count_reg <= pwdata[4:0];
            if (reg_sel == REG_PERSIST) persistence_reg  <= pwdata[15:0];
        end
    end

    // Handshake
    assign in_ch.ready        = (state_reg == S_IDLE);
    assign in_fire            = in_ch.valid & in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.noise_value = noise_reg;

    // Clamp the octave count and persistence at evaluation start
    assign n_clamp    = (int'(octave_count_reg) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                               : OCT_W'(octave_count_reg);
    assign pers_clamp = (persistence_reg > AMP_ONE) ? AMP_ONE : persistence_reg;

    // Cell and fraction fields of the scaled point
    assign fx = px_reg[FRAC_BITS-1:0];
    assign fy = py_reg[FRAC_BITS-1:0];
    assign cx = px_reg[PX_W-1:FRAC_BITS];
    assign cy = py_reg[PX_W-1:FRAC_BITS];

    // Fade polynomial first factor: 6t - 15
    assign t_sel  = fade_y_reg ? fy : fx;
    assign t_ext  = {5'd0, t_sel};
    assign fade_a = $signed((t_ext << 2) + (t_ext << 1) - FIFTEEN_FW);
    assign f_raw  = $signed(prod_reg[FRAC_BITS +: FW]);

    always_comb
    begin
        priority if (f_raw[FW-1])
            f_clamp = '0;
        else if (f_raw > $signed(ONE_FW))
            f_clamp = ONE_FW[FRAC_BITS:0];
        else
            f_clamp = f_raw[FRAC_BITS:0];
    end

    // Corner dot products and lerp differences
    assign dxp     = $signed({3'd0, fx});
    assign dyp     = $signed({3'd0, fy});
    assign dxn     = dxp - $signed(ONE_DW);
    assign dyn     = dyp - $signed(ONE_DW);
    assign d00     = dot_sel(g00_reg, dxp, dyp);
    assign d10     = dot_sel(g10_reg, dxn, dyp);
    assign d01     = dot_sel(g01_reg, dxp, dyn);
    assign d11     = dot_sel(g11_reg, dxn, dyn);
    assign diff_x0 = d10 - d00;
    assign diff_x1 = d11 - d01;
    assign diff_y  = bot_reg - top_reg;
    assign prod_shr = $signed(prod_reg[FRAC_BITS +: DW]);
    assign v_w     = top_reg + prod_shr;
    assign absv_w  = v_w[DW-1] ? -v_w : v_w;

    // Scaled point extraction with sign extension
    assign prod_ext = {{(EXT_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SCX:
            begin
                mul_a = {coord_x_reg[31], coord_x_reg};
                mul_b = {1'b0, scale_reg};
            end
            S_SCY:
            begin
                mul_a = {coord_y_reg[31], coord_y_reg};
                mul_b = {1'b0, scale_reg};
            end
            S_HX:
            begin
                mul_a = {1'b0, cx};
                mul_b = {1'b0, HASH_MUL_X};
            end
            S_HY:
            begin
                mul_a = {1'b0, cy};
                mul_b = {1'b0, HASH_MUL_Y};
            end
            S_FA:
            begin
                mul_a = {{(MUL_W-FRAC_BITS){1'b0}}, t_sel};
                mul_b = {{(MUL_W-FW){fade_a[FW-1]}}, fade_a};
            end
            S_FB:
            begin
                mul_a = {{(MUL_W-FRAC_BITS){1'b0}}, t_sel};
                mul_b = {{(MUL_W-FRAC_BITS){1'b0}}, t_sel};
            end
            S_FC:
            begin
                mul_a = {{(MUL_W-FRAC_BITS){1'b0}}, prod_reg[FRAC_BITS +: FRAC_BITS]};
                mul_b = {{(MUL_W-FRAC_BITS){1'b0}}, t_sel};
            end
            S_FD:
            begin
                mul_a = {{(MUL_W-FRAC_BITS){1'b0}}, prod_reg[FRAC_BITS +: FRAC_BITS]};
                mul_b = {{(MUL_W-FW){b_reg[FW-1]}}, b_reg};
            end
            S_L1:
            begin
                mul_a = {{(MUL_W-DW){diff_x0[DW-1]}}, diff_x0};
                mul_b = {{(MUL_W-FRAC_BITS-1){1'b0}}, wx_reg};
            end
            S_L2:
            begin
                mul_a = {{(MUL_W-DW){diff_x1[DW-1]}}, diff_x1};
                mul_b = {{(MUL_W-FRAC_BITS-1){1'b0}}, wx_reg};
            end
            S_L4:
            begin
                mul_a = {{(MUL_W-DW){diff_y[DW-1]}}, diff_y};
                mul_b = {{(MUL_W-FRAC_BITS-1){1'b0}}, wy_reg};
            end
            S_L6:
            begin
                mul_a = {{(MUL_W-FRAC_BITS-1){1'b0}}, absv_reg};
                mul_b = {{(MUL_W-16){1'b0}}, amp_reg};
            end
            S_L7:
            begin
                mul_a = {{(MUL_W-16){1'b0}}, amp_reg};
                mul_b = {{(MUL_W-16){1'b0}}, pers_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Register every product before its use
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Corner hash addresses
    assign hx1 = hx_reg + HASH_MUL_X;
    assign hy0 = prod_reg[31:0] + HASH_ADD;
    assign hy1 = hy_reg + HASH_MUL_Y;

    always_comb
    begin
        unique case (state_reg)
            S_R00:   hash_w = hx_reg ^ hy0;
            S_R10:   hash_w = hx1 ^ hy_reg;
            S_R01:   hash_w = hx_reg ^ hy1;
            S_R11:   hash_w = hx1 ^ hy1;
            default: hash_w = 32'd0;
        endcase
    end
    assign rd_addr = hash_w[IDX_W-1:0];

    // Gradient table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.opcode == OP_WRITE)
            gmem[in_ch.table_index] <= in_ch.table_value[1:0];
        rdata_reg <= gmem[rd_addr];
    end

    // Sequencer
    assign oct_inc = oct_reg + 1'b1;
    assign rem_ge  = (rem_reg >= dsh_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire && in_ch.opcode == OP_EVAL) state_next = S_SCX;
            S_SCX:  state_next = S_SCY;
            S_SCY:  state_next = S_PY;
            S_PY:   state_next = (n_reg == '0) ? S_DV0 : S_HX;
            S_HX:   state_next = S_HY;
            S_HY:   state_next = S_R00;
            S_R00:  state_next = S_R10;
            S_R10:  state_next = S_R01;
            S_R01:  state_next = S_R11;
            S_R11:  state_next = S_G11;
            S_G11:  state_next = S_FA;
            S_FA:   state_next = S_FB;
            S_FB:   state_next = S_FC;
            S_FC:   state_next = S_FD;
            S_FD:   state_next = S_FE;
            S_FE:   state_next = fade_y_reg ? S_L1 : S_FA;
            S_L1:   state_next = S_L2;
            S_L2:   state_next = S_L3;
            S_L3:   state_next = S_L4;
            S_L4:   state_next = S_L5;
            S_L5:   state_next = S_L6;
            S_L6:   state_next = S_L7;
            S_L7:   state_next = S_L8;
            S_L8:   state_next = (oct_inc == n_reg) ? S_DV0 : S_HX;
            S_DV0:  state_next = (total_reg == '0) ? S_DONE : S_DIV;
            S_DIV:  state_next = (bit_cnt_reg == 4'd0) ? S_DONE : S_DIV;
            S_DONE: if (!out_valid_reg || out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            fade_y_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Load the result, or drop it once taken
            if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_FE)
                fade_y_reg <= ~fade_y_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                coord_x_reg <= in_ch.coord_x;
                coord_y_reg <= in_ch.coord_y;
                n_reg       <= n_clamp;
                pers_reg    <= pers_clamp;
                amp_reg     <= AMP_ONE;
                oct_reg     <= '0;
                sum_reg     <= '0;
                total_reg   <= '0;
            end
            S_SCY:  px_reg  <= prod_ext[(SCALE_SHIFT_BASE-FRAC_BITS) +: PX_W];
            S_PY:   py_reg  <= prod_ext[(SCALE_SHIFT_BASE-FRAC_BITS) +: PX_W];
            S_HY:   hx_reg  <= prod_reg[31:0];
            S_R00:  hy_reg  <= hy0;
            S_R10:  g00_reg <= rdata_reg;
            S_R01:  g10_reg <= rdata_reg;
            S_R11:  g01_reg <= rdata_reg;
            S_G11:  g11_reg <= rdata_reg;
            S_FB:   b_reg   <= $signed(prod_reg[FRAC_BITS +: FW]) + $signed(TEN_FW);
            S_FE:
            begin
                if (fade_y_reg)
                    wy_reg <= f_clamp;
                else
                    wx_reg <= f_clamp;
            end
            // Top edge lerp starts from the d00 corner
            S_L2:   top_reg <= d00 + prod_shr;
            S_L3:   bot_reg <= d01 + prod_shr;
            S_L5:   absv_reg <= absv_w[FRAC_BITS:0];
            S_L7:
            begin
                sum_reg   <= sum_reg + prod_reg[SUM_W-1:0];
                total_reg <= total_reg + TOT_W'(amp_reg);
            end
            S_L8:
            begin
                amp_reg <= prod_reg[30:15];
                px_reg  <= px_reg << 1;
                py_reg  <= py_reg << 1;
                oct_reg <= oct_inc;
            end
            S_DV0:
            begin
                rem_reg     <= {sum_reg, 15'd0};
                dsh_reg     <= {total_reg, {(FRAC_BITS+15){1'b0}}};
                bit_cnt_reg <= 4'd15;
                q_reg       <= 16'd0;
            end
            S_DIV:
            begin
                if (rem_ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg       <= {q_reg[14:0], rem_ge};
                dsh_reg     <= dsh_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg - 4'd1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                    noise_reg <= (q_reg > AMP_ONE) ? AMP_ONE : q_reg;
            end
            default:
            begin
                oct_reg <= oct_reg;
            end
        endcase
    end

endmodule

@@ hdl/pno_checker.sv @@
// Port-level checks for the fractal gradient noise block, bound to its top level.
// Depends on pno_pkg and perlin_noise_2d_octaves_top.
module pno_checker
    import pno_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_noise,
    input logic        pready
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_noise))
        else $error("result item changed while stalled");

    // Keep results within Q1.15 one
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_noise <= AMP_ONE)
        else $error("noise value above one");

    // Drop ready after taking an evaluate item
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_opcode == OP_EVAL |=> !in_ready)
        else $error("ready stayed high during evaluation");

    // Raise a new result only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while busy");

    // Never wait states on the register port
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind perlin_noise_2d_octaves_top pno_checker u_pno_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_noise (out_ch.noise_value),
    .pready    (pready)
);

@@ tb/testbench.sv @@
// Self-checking bench for the fractal gradient noise block: table writes, evaluations, registers.
// Depends on pno_pkg, pno_in_if, pno_out_if and perlin_noise_2d_octaves_top.
module testbench;
    import pno_pkg::*;

    localparam int FRAC      = DEF_FRAC_BITS;
    localparam longint ONE   = 64'sd1 << FRAC;
    localparam int LIMIT     = 3000000;
    localparam int DRAIN_CYC = 25 * DEF_MAX_OCTAVES + 60;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pno_in_if  in_ch();
    pno_out_if out_ch();

    perlin_noise_2d_octaves_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's registers and gradient table
    bit [1:0]  grad_tbl [TABLE_DEPTH];
    bit [31:0] sh_scale;
    bit [4:0]  sh_octaves;
    bit [15:0] sh_persist;

    bit [15:0] expected_noise [$];
    int        errors;
    int        cycles;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        stall_req;
    int        stall_cnt;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random idling, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            stall_req = 1'b0;
            stall_cnt = 800;
        end
        if (stall_cnt > 0)
        begin
            stall_cnt = stall_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_noise.size() == 0)
            begin
                $display("%0t: unexpected noise_value, expected none, actual %0d",
                         $time, out_ch.noise_value);
                errors++;
            end
            else
            begin
                bit [15:0] want;
                want = expected_noise.pop_front();
                if (out_ch.noise_value !== want)
                begin
                    $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                             $time, want, out_ch.noise_value);
                    errors++;
                end
            end
        end
    end

    // Quintic fade, stepwise, each step rounded down
    function automatic longint fade_q(longint t);
        longint a, b, c, d, f;
        a = 6 * t - 15 * ONE;
        b = ((t * a) >>> FRAC) + 10 * ONE;
        c = (t * t) >>> FRAC;
        d = (c * t) >>> FRAC;
        f = (d * b) >>> FRAC;
        if (f < 0) f = 0;
        if (f > ONE) f = ONE;
        return f;
    endfunction

    function automatic longint lerp_q(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> FRAC);
    endfunction

    // Dot product of the hashed corner gradient with the offset
    function automatic longint corner_grad(bit [31:0] cx, bit [31:0] cy, longint dx,
                                           longint dy);
        bit [31:0] h;
        h = (cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y + HASH_ADD);
        case (grad_tbl[h[IDX_W-1:0]])
            GRAD_POS_X: return dx;
            GRAD_NEG_X: return -dx;
            GRAD_POS_Y: return dy;
            default:    return -dy;
        endcase
    endfunction

    function automatic longint octave_abs(bit [63:0] px, bit [63:0] py);
        bit [31:0] cx, cy;
        longint fx, fy, d00, d10, d01, d11, wx, wy, top, bot, v;
        cx  = px[FRAC+31:FRAC];
        cy  = py[FRAC+31:FRAC];
        fx  = longint'({48'd0, px[FRAC-1:0]});
        fy  = longint'({48'd0, py[FRAC-1:0]});
        d00 = corner_grad(cx, cy, fx, fy);
        d10 = corner_grad(cx + 1, cy, fx - ONE, fy);
        d01 = corner_grad(cx, cy + 1, fx, fy - ONE);
        d11 = corner_grad(cx + 1, cy + 1, fx - ONE, fy - ONE);
        wx  = fade_q(fx);
        wy  = fade_q(fy);
        top = lerp_q(d00, d10, wx);
        bot = lerp_q(d01, d11, wx);
        v   = lerp_q(top, bot, wy);
        return (v < 0) ? -v : v;
    endfunction

    // Full evaluation: scale, sum octaves, normalize, saturate
    function automatic bit [15:0] predict_noise(logic signed [31:0] x, logic signed [31:0] y);
        int unsigned n;
        bit [63:0]   amp, pers, total, sum, den, q, px, py;
        longint      sc;
        n     = (sh_octaves > DEF_MAX_OCTAVES) ? DEF_MAX_OCTAVES : sh_octaves;
        pers  = (sh_persist > AMP_ONE) ? AMP_ONE : sh_persist;
        amp   = AMP_ONE;
        total = 0;
        sum   = 0;
        sc    = longint'({32'd0, sh_scale});
        px    = (longint'(x) * sc) >>> (SCALE_SHIFT_BASE - FRAC);
        py    = (longint'(y) * sc) >>> (SCALE_SHIFT_BASE - FRAC);
        for (int k = 0; k < n; k++)
        begin
            total += amp;
            sum   += octave_abs(px, py) * amp;
            amp    = (amp * pers) >> 15;
            px     = px << 1;
            py     = py << 1;
        end
        den = total << FRAC;
        if (den == 0)
            q = 0;
        else
        begin
            q = (sum << 15) / den;
            if (q > AMP_ONE) q = AMP_ONE;
        end
        return q[15:0];
    endfunction

    // Offer one item, wait for acceptance, then record what it predicts;
    // valid stays up until the next item or wait_idle drops it
    task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [7:0] val,
                             logic signed [31:0] x, logic signed [31:0] y);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.table_index <= idx;
        in_ch.table_value <= val;
        in_ch.coord_x     <= x;
        in_ch.coord_y     <= y;
        do @(posedge clk); while (!in_ch.ready);
        if (op == OP_WRITE)
            grad_tbl[idx] = val[1:0];
        else
            expected_noise.push_back(predict_noise(x, y));
    endtask

    task automatic send_eval(logic signed [31:0] x, logic signed [31:0] y);
        send_item(OP_EVAL, IDX_W'($urandom), 8'($urandom), x, y);
    endtask

    function automatic logic signed [7:0] rand_byte();
        return 8'($urandom_range(254)) - 8'sd127;
    endfunction

    // Drop valid, let all results drain, then give the block a quiet moment
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_noise.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCALE:   sh_scale   = value;
            REG_OCTAVES: sh_octaves = value[4:0];
            default:     sh_persist = value[15:0];
        endcase
    endtask

    task automatic set_config(logic [31:0] sc, logic [31:0] oc, logic [31:0] ps);
        write_reg(REG_SCALE, sc);
        write_reg(REG_OCTAVES, oc);
        write_reg(REG_PERSIST, ps);
    endtask

    // Fill every table entry so no evaluation reads an unwritten one
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(OP_WRITE, IDX_W'(i), rand_byte(), $urandom, $urandom);
        send_item(OP_WRITE, '1, 8'sd127, 32'sd0, 32'sd0);
        send_item(OP_WRITE, '0, -8'sd127, 32'sd0, 32'sd0);
    endtask

    // Extremes of coordinates and registers, and each special case
    task automatic test_directed();
        send_eval(32'sd0, 32'sd0);
        send_eval(32'h7FFF_FFFF, 32'h8000_0000);
        send_eval(32'h8000_0000, 32'h7FFF_FFFF);
        send_eval(32'h0000_8000, 32'h0001_4000);
        set_config(32'hFFFF_FFFF, 16, 32768);
        send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eval(32'h8000_0000, 32'h8000_0000);
        send_eval(32'h0000_C123, 32'hFFFF_3EDD);
        // zero octaves gives zero
        set_config(32'd0, 0, 16384);
        send_eval(32'h1234_5678, 32'h8765_4321);
        set_config(32'h0100_0000, 0, 16384);
        send_eval(32'h0003_8000, 32'h0002_1000);
        // octave count beyond the maximum is clamped
        write_reg(REG_OCTAVES, 31);
        send_eval(32'h0003_8000, 32'h0002_1000);
        write_reg(REG_OCTAVES, 17);
        send_eval(32'hFFFE_0001, 32'h0000_FFFF);
        // persistence above one is clamped, zero kills later octaves
        write_reg(REG_PERSIST, 32'h0000_FFFF);
        send_eval(32'h0001_7777, 32'h0005_9999);
        write_reg(REG_PERSIST, 0);
        send_eval(32'h0001_7777, 32'h0005_9999);
        write_reg(REG_PERSIST, 32769);
        write_reg(REG_OCTAVES, 3);
        send_eval(32'h0000_0001, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 10'd512, 8'sd3, 32'sd0, 32'sd0);
        send_eval(32'h0000_0001, 32'hFFFF_FFFF);
    endtask

    // Random traffic: mostly evaluations, some table writes, a few register settings
    task automatic test_random(int count);
        for (int c = 0; c < 3; c++)
        begin
            logic [31:0] sc;
            int          oc;
            case ($urandom_range(3))
                0:       sc = $urandom;
                1:       sc = 32'h0100_0000;
                2:       sc = $urandom_range(32'h0400_0000);
                default: sc = 32'hFFFF_FFFF - $urandom_range(255);
            endcase
            oc = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
            set_config(sc, oc, $urandom_range(65535));
            for (int i = 0; i < count / 3; i++)
            begin
                if ($urandom_range(3) == 0)
                    send_item(OP_WRITE, IDX_W'($urandom), rand_byte(), $urandom, $urandom);
                else if ($urandom_range(1))
                    send_eval($urandom, $urandom);
                else
                    send_eval($signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000,
                              $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
            end
        end
    endtask

    // Hold off the receiver long enough that the block stalls its input
    task automatic test_backpressure();
        set_config(32'h0100_0000, 1, 16384);
        stall_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_eval($urandom, $urandom);
        wait_idle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_WRITE;
        in_ch.table_index = '0;
        in_ch.table_value = '0;
        in_ch.coord_x     = '0;
        in_ch.coord_y     = '0;
        out_ch.ready      = 1'b0;
        errors            = 0;
        cycles            = 0;
        stall_req         = 1'b0;
        stall_cnt         = 0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        sh_scale          = SCALE_RST;
        sh_octaves        = OCTAVES_RST;
        sh_persist        = PERSIST_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 8;
        rx_idle_pct = 47;
        test_table_fill();
        test_directed();
        test_random(180);
        test_backpressure();
        tx_idle_pct = 47;
        rx_idle_pct = 8;
        test_random(180);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(180);

        wait_idle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && expected_noise.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
